FILE: src/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Types and constants shared by the length-prefixed frame decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpfd_pkg;

    localparam logic [7:0] ESCAPE_LEN   = 8'd255;
    localparam int         QUEUE_DEPTH  = 4;
    localparam int         QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int         QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_EMPTY     = 2'd1,
        KIND_COMPLETE  = 2'd2,
        KIND_MALFORMED = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_LEN = 3'b001,
        PH_EXT = 3'b010,
        PH_PAY = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       buffer_end;
    } lpfd_in_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       frame_end;
        logic       run_last;
    } lpfd_out_t;

    // Results produced by one input beat: a count of zero, one or two.
    typedef struct packed {
        logic [1:0] count;
        lpfd_out_t  res0;
        lpfd_out_t  res1;
    } lpfd_step_t;

endpackage

FILE: src/lpfd_parser.sv
// ----------------------------------------------------------------------------
// lpfd_parser
// Frame state and per-beat decode: turns one encoded byte into up to two results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfd_parser
    import lpfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  lpfd_in_t   beat,
    output lpfd_step_t step
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [1:0]  ext_cnt_reg;
    logic [1:0]  ext_cnt_next;
    logic [31:0] rem_reg;
    logic [31:0] rem_next;

    logic [31:0] rem_dec;
    logic [31:0] rem_shift;
    logic [1:0]  ext_cnt_inc;
    logic        frame_open;
    logic        have0;
    lpfd_out_t   r0;
    lpfd_out_t   status;

    assign rem_dec     = rem_reg - 32'd1;
    assign rem_shift   = {rem_reg[23:0], beat.in_byte};
    assign ext_cnt_inc = ext_cnt_reg + 2'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        ext_cnt_next = ext_cnt_reg;
        rem_next     = rem_reg;
        frame_open   = 1'b0;
        have0        = 1'b0;
        r0           = '{kind: KIND_PAYLOAD, data_byte: 8'd0, frame_end: 1'b0,
                         run_last: 1'b0};

        case (phase_reg)
            PH_PAY:
            begin
                rem_next     = rem_dec;
                frame_open   = (rem_dec != 32'd0);
                have0        = 1'b1;
                r0.data_byte = beat.in_byte;
                r0.frame_end = (rem_dec == 32'd0);
                if (rem_dec == 32'd0)
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_EXT:
            begin
                rem_next     = rem_shift;
                ext_cnt_next = ext_cnt_inc;
                frame_open   = 1'b1;
                // The fourth length byte wraps the counter back to zero.
                if (ext_cnt_inc == 2'd0)
                begin
                    if (rem_shift == 32'd0)
                    begin
                        have0        = 1'b1;
                        r0.kind      = KIND_EMPTY;
                        r0.frame_end = 1'b1;
                        phase_next   = PH_LEN;
                        frame_open   = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_PAY;
                    end
                end
            end
            default:
            begin
                if (beat.in_byte == ESCAPE_LEN)
                begin
                    phase_next   = PH_EXT;
                    ext_cnt_next = 2'd0;
                    rem_next     = 32'd0;
                    frame_open   = 1'b1;
                end
                else if (beat.in_byte == 8'd0)
                begin
                    have0        = 1'b1;
                    r0.kind      = KIND_EMPTY;
                    r0.frame_end = 1'b1;
                    phase_next   = PH_LEN;
                end
                else
                begin
                    rem_next   = {24'd0, beat.in_byte};
                    phase_next = PH_PAY;
                    frame_open = 1'b1;
                end
            end
        endcase

        status = '{kind: (frame_open ? KIND_MALFORMED : KIND_COMPLETE),
                   data_byte: 8'd0, frame_end: 1'b0, run_last: 1'b1};

        // The end of the buffer appends a status result and starts a new message.
        if (beat.buffer_end)
        begin
            phase_next   = PH_LEN;
            ext_cnt_next = 2'd0;
            rem_next     = 32'd0;
        end

        step.res0 = r0;
        step.res1 = status;
        if (beat.buffer_end && have0)
        begin
            step.count = 2'd2;
        end
        else if (beat.buffer_end)
        begin
            step.count = 2'd1;
            step.res0  = status;
        end
        else if (have0)
        begin
            step.count         = 2'd1;
            step.res0.run_last = 1'b1;
        end
        else
        begin
            step.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEN;
            ext_cnt_reg <= 2'd0;
            rem_reg     <= 32'd0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            ext_cnt_reg <= ext_cnt_next;
            rem_reg     <= rem_next;
        end
    end

endmodule

FILE: src/lpfd_out_queue.sv
// ----------------------------------------------------------------------------
// lpfd_out_queue
// Small result queue that takes up to two results per cycle and sends one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfd_out_queue
    import lpfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  lpfd_step_t step,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output lpfd_out_t  out_data
);

    lpfd_out_t            entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg;
    logic [QCNT_W-1:0]    count_next;
    logic [1:0]           n_push;
    logic                 pop;

    assign n_push    = push ? step.count : 2'd0;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = entries[rd_ptr_reg];
    // Room for the worst case of two results from the next beat.
    assign room      = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign count_next  = count_reg + QCNT_W'(n_push) - QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            entries[wr_ptr_reg] <= step.res0;
        end
        if (n_push == 2'd2)
        begin
            entries[wr_ptr_reg + QPTR_W'(1)] <= step.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/length_prefixed_frame_decoder.sv
// A result appears on out_valid once its input beat has passed the input register and
// been written into the queue, later when the queue lacks room or earlier results wait.
// Throughput: one input beat per cycle unless stalled; results leave one per cycle from
// a four-entry queue, so a beat that yields two results (end of buffer after a payload
// byte or an empty frame) sends two beats, and input stalls while more than two wait.
// Reset (rst_n, asynchronous): frame state returns to expecting a length byte and the
// input register and queue empty.
// ----------------------------------------------------------------------------
// length_prefixed_frame_decoder
// Decodes a byte stream of length-prefixed frames with a 255 escape to a 32-bit length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_frame_decoder
    import lpfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lpfd_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output lpfd_out_t out_data
);

    logic       in_valid_reg;
    logic       in_valid_next;
    lpfd_in_t   in_data_reg;
    logic       room;
    logic       fire;
    logic       load;
    lpfd_step_t step;

    // A held beat moves into the parser when the queue can take all its results.
    assign fire     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || room;
    assign load     = in_valid && in_ready;

    assign in_valid_next = load ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_data_reg <= in_data;
        end
    end

    lpfd_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .beat  (in_data_reg),
        .step  (step)
    );

    lpfd_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .step      (step),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: dv/lpfd_frame_checker.sv
// ----------------------------------------------------------------------------
// lpfd_frame_checker
// Watches both channels of the frame decoder, decodes every accepted input
// beat on its own to predict the results, and compares each result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfd_frame_checker
    import lpfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  lpfd_in_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  lpfd_out_t out_data,
    output int        mismatches,
    output int        outstanding
);

    phase_t      dec_phase;
    logic [1:0]  ext_seen;
    logic [31:0] remaining;
    lpfd_out_t   results_due [$];
    int          fail_total = 0;
    int          due_total  = 0;

    assign mismatches  = fail_total;
    assign outstanding = due_total;

    function automatic lpfd_out_t make_result(kind_t k, logic [7:0] d, logic fe);
        lpfd_out_t r;
        r.kind      = k;
        r.data_byte = d;
        r.frame_end = fe;
        r.run_last  = 1'b0;
        return r;
    endfunction

    task automatic clear_state();
        dec_phase = PH_LEN;
        ext_seen  = 2'd0;
        remaining = 32'd0;
    endtask

    // Decodes one accepted byte and queues the results it is due to cause.
    task automatic decode_byte(input lpfd_in_t beat);
        lpfd_out_t r [2];
        int        n;
        int        i;
        logic      open;
        n    = 0;
        open = 1'b0;
        case (dec_phase)
            PH_PAY:
            begin
                remaining = remaining - 32'd1;
                open = (remaining != 32'd0);
                r[n] = make_result(KIND_PAYLOAD, beat.in_byte, !open);
                n++;
                if (!open)
                begin
                    dec_phase = PH_LEN;
                end
            end
            PH_EXT:
            begin
                remaining = {remaining[23:0], beat.in_byte};
                ext_seen  = ext_seen + 2'd1;
                // The two-bit count wraps to zero once all four length bytes are in.
                if (ext_seen != 2'd0)
                begin
                    open = 1'b1;
                end
                else if (remaining == 32'd0)
                begin
                    r[n] = make_result(KIND_EMPTY, 8'h00, 1'b1);
                    n++;
                    dec_phase = PH_LEN;
                end
                else
                begin
                    dec_phase = PH_PAY;
                    open = 1'b1;
                end
            end
            default:
            begin
                if (beat.in_byte == ESCAPE_LEN)
                begin
                    dec_phase = PH_EXT;
                    ext_seen  = 2'd0;
                    remaining = 32'd0;
                    open      = 1'b1;
                end
                else if (beat.in_byte == 8'h00)
                begin
                    r[n] = make_result(KIND_EMPTY, 8'h00, 1'b1);
                    n++;
                    dec_phase = PH_LEN;
                end
                else
                begin
                    remaining = {24'd0, beat.in_byte};
                    dec_phase = PH_PAY;
                    open      = 1'b1;
                end
            end
        endcase
        if (beat.buffer_end)
        begin
            r[n] = make_result(open ? KIND_MALFORMED : KIND_COMPLETE, 8'h00, 1'b0);
            n++;
            clear_state();
        end
        if (n > 0)
        begin
            r[n - 1].run_last = 1'b1;
            for (i = 0; i < n; i++)
            begin
                results_due.push_back(r[i]);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lpfd_out_t got;
        lpfd_out_t want;
        logic      bad;
        if (!rst_n)
        begin
            clear_state();
            results_due.delete();
            due_total <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_byte(in_data);
            end
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat: kind %0d data %02h frame_end %0b run_last %0b",
                             $time, got.kind, got.data_byte, got.frame_end, got.run_last);
                    fail_total++;
                end
                else
                begin
                    want = results_due.pop_front();
                    bad  = 1'b0;
                    if (got.kind !== want.kind)
                    begin
                        $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                        bad = 1'b1;
                    end
                    if (got.data_byte !== want.data_byte)
                    begin
                        $display("%0t: data_byte expected %02h actual %02h",
                                 $time, want.data_byte, got.data_byte);
                        bad = 1'b1;
                    end
                    if (got.frame_end !== want.frame_end)
                    begin
                        $display("%0t: frame_end expected %0b actual %0b",
                                 $time, want.frame_end, got.frame_end);
                        bad = 1'b1;
                    end
                    if (got.run_last !== want.run_last)
                    begin
                        $display("%0t: run_last expected %0b actual %0b",
                                 $time, want.run_last, got.run_last);
                        bad = 1'b1;
                    end
                    if (bad)
                    begin
                        fail_total++;
                    end
                end
            end
            due_total <= results_due.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives encoded multi-frame messages into the frame decoder: a directed set
// of corner cases, then random well-formed, truncated and noisy messages,
// with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import lpfd_pkg::*;

    localparam int TARGET_BEATS = 1900;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    lpfd_in_t   in_data;
    logic       out_valid;
    logic       out_ready = 1'b0;
    lpfd_out_t  out_data;
    int         mismatches;
    int         outstanding;

    logic [7:0] msg [$];
    int         beats_sent = 0;
    bit         in_calm    = 1'b0;
    bit         out_calm   = 1'b0;
    int         stall_left = 0;

    length_prefixed_frame_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    lpfd_frame_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 95)
        begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(20, 40);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!out_calm && $urandom_range(0, 3) == 0)
            begin
                stall_left <= idle_len();
            end
        end
        if ($urandom_range(0, 199) == 0)
        begin
            out_calm <= ~out_calm;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if (!in_calm && $urandom_range(0, 2) == 0)
        begin
            gap = idle_len();
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{in_byte: b, buffer_end: last};
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    // Sends the message up to and including byte upto, which carries the end mark.
    task automatic send_message(input int upto);
        int i;
        for (i = 0; i <= upto; i++)
        begin
            send_byte(msg[i], i == upto);
        end
    endtask

    task automatic build_message();
        int          frames;
        int          f;
        int          k;
        int          r;
        int          len;
        logic [31:0] ext_len;
        msg.delete();
        frames = $urandom_range(1, 4);
        for (f = 0; f < frames; f++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                len = 0;
            end
            else if (r < 72)
            begin
                len = $urandom_range(1, 8);
            end
            else if (r < 74)
            begin
                len = $urandom_range(100, 254);
            end
            else
            begin
                len = (r < 80) ? 0 : $urandom_range(1, 8);
            end
            if (r >= 74)
            begin
                ext_len = len;
                msg.push_back(ESCAPE_LEN);
                msg.push_back(ext_len[31:24]);
                msg.push_back(ext_len[23:16]);
                msg.push_back(ext_len[15:8]);
                msg.push_back(ext_len[7:0]);
            end
            else
            begin
                msg.push_back(len[7:0]);
            end
            for (k = 0; k < len; k++)
            begin
                msg.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int r;
        int k;
        int n;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Empty frame closing the buffer.
        msg = '{8'h00};
        send_message(msg.size() - 1);
        // Extended zero length, end mark on the last length byte.
        msg = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
        send_message(msg.size() - 1);
        // Extended length of two with extreme payload bytes.
        msg = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00};
        send_message(msg.size() - 1);
        // Buffer ends on a plain length byte, on the escape, inside the extended length.
        msg = '{8'h05};
        send_message(msg.size() - 1);
        msg = '{8'hFF};
        send_message(msg.size() - 1);
        msg = '{8'hFF, 8'h00};
        send_message(msg.size() - 1);
        // Buffer ends inside a payload.
        msg = '{8'h02, 8'hA5};
        send_message(msg.size() - 1);
        msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A};
        send_message(msg.size() - 1);
        // Two frames, the second one empty.
        msg = '{8'h01, 8'h7E, 8'h00};
        send_message(msg.size() - 1);

        while (beats_sent < TARGET_BEATS)
        begin
            in_calm = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                build_message();
                send_message(msg.size() - 1);
            end
            else if (r < 93)
            begin
                build_message();
                send_message($urandom_range(0, msg.size() - 1));
            end
            else
            begin
                msg.delete();
                n = $urandom_range(1, 10);
                for (k = 0; k < n; k++)
                begin
                    msg.push_back(8'($urandom_range(0, 255)));
                end
                send_message(msg.size() - 1);
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
